/* design/ola_pkg.sv */
// Package for the ordered array list engine.
// Holds the field widths, record layout, operation and status codes and FSM states.
// No dependencies.
`default_nettype none

package ola_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int CNT_W_DEF    = $clog2(CAPACITY_DEF + 1);
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 3;
    localparam int CODE_W       = 32;
    localparam int NAME_W       = 64;
    localparam int PAY_W        = 64;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_PREPEND   = 3'd1,
        OP_INS_AFTER = 3'd2,
        OP_FIND      = 3'd3,
        OP_POP_FRONT = 3'd4,
        OP_POP_BACK  = 3'd5,
        OP_DEL_CODE  = 3'd6,
        OP_CLEAR     = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_MISS  = 3'd3,
        ST_DUP   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FETCH,
        S_TAKE,
        S_SH_UP,
        S_SH_DN,
        S_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [NAME_W-1:0] name;
        logic [PAY_W-1:0]  payload;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

endpackage

`default_nettype wire

/* design/ola_req_if.sv */
// Request channel of the ordered array list engine: valid, ready and one operation beat.
// Depends on ola_pkg for the field widths.
`default_nettype none

interface ola_req_if import ola_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [CODE_W-1:0] rec_code;
    logic [NAME_W-1:0]        rec_name;
    logic [NAME_W-1:0]        match_name;
    logic [PAY_W-1:0]         rec_payload;

    modport source (output valid, op, rec_code, rec_name, match_name, rec_payload,
                    input ready);
    modport sink   (input valid, op, rec_code, rec_name, match_name, rec_payload,
                    output ready);
endinterface

`default_nettype wire

/* design/ola_rsp_if.sv */
// Response channel of the ordered array list engine: valid, ready and one result beat.
// Depends on ola_pkg for the field widths and the default count width.
`default_nettype none

interface ola_rsp_if import ola_pkg::*; #(
    parameter int CNT_W = CNT_W_DEF
);
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [CODE_W-1:0] found_code;
    logic [NAME_W-1:0]        found_name;
    logic [PAY_W-1:0]         found_payload;
    logic [CNT_W-1:0]         fill_count;

    modport source (output valid, status, found_code, found_name, found_payload, fill_count,
                    input ready);
    modport sink   (input valid, status, found_code, found_name, found_payload, fill_count,
                    output ready);
endinterface

`default_nettype wire

/* design/ola_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module ola_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/ordered_array_list_engine.sv */
// Ordered array list engine: records held in one RAM, handled by a read-modify-write sequencer.
// Append, clear and operations rejected as full or empty go from decode straight to the done state.
// Find, insert-after and delete-code scan all held records, and a shift then moves the records
// one by one (RAM has one read and one write port).
// One operation at a time; the engine returns to idle once the result loads and then takes the next beat.
// Synchronous active-low reset empties the list; the RAM contents are not cleared.
`default_nettype none

module ordered_array_list_engine import ola_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ola_req_if.sink     i_req,
    ola_rsp_if.source   o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovalid, n_ovalid;

    logic [OP_W-1:0]   r_op, n_op;
    logic [CODE_W-1:0] r_code, n_code;
    logic [NAME_W-1:0] r_name, n_name;
    logic [NAME_W-1:0] r_match, n_match;
    logic [PAY_W-1:0]  r_pay, n_pay;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_ridx, n_ridx;
    logic [CW-1:0]     r_pos, n_pos;
    logic              r_rv, n_rv;
    logic              r_issue, n_issue;
    logic              r_hit, n_hit;
    logic              r_dup, n_dup;
    t_status           r_status, n_status;
    t_rec              r_found, n_found;
    t_status           r_ostatus, n_ostatus;
    t_rec              r_orec, n_orec;
    logic [CW-1:0]     r_ofill, n_ofill;

    logic              ram_we;
    logic [CW-1:0]     w_waddr, w_raddr;
    t_rec              ram_wdata;
    logic [REC_W-1:0]  ram_rdata;
    t_rec              rd;

    t_op               op;
    logic              accept, full, empty, scan_end, key_hit, code_hit, load, report;
    logic [CW-1:0]     ridx_up, ridx_dn, pos_up, cnt_dn, idx_up, idx_dn;

    ola_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (w_waddr[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd       = t_rec'(ram_rdata);
    assign op       = t_op'(r_op);
    assign accept   = i_req.valid && i_req.ready;
    assign full     = r_count >= CW'(CAPACITY);
    assign empty    = r_count == '0;
    assign scan_end = (r_idx >= r_count) && !r_rv;
    assign key_hit  = r_rv && ((op == OP_DEL_CODE) ? (rd.code == r_code) : (rd.name == r_match));
    assign code_hit = r_rv && (rd.code == r_code);
    assign load     = (r_state == S_DONE) && (!r_ovalid || o_rsp.ready);
    assign ridx_up  = r_ridx + 1'b1;
    assign ridx_dn  = r_ridx - 1'b1;
    assign pos_up   = r_pos + 1'b1;
    assign cnt_dn   = r_count - 1'b1;
    assign idx_up   = r_idx + 1'b1;
    assign idx_dn   = r_idx - 1'b1;

    always_comb begin
        case (op) inside
            OP_FIND, OP_POP_FRONT, OP_POP_BACK, OP_DEL_CODE: report = (r_status == ST_OK);
            default:                                          report = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (op)
                    OP_APPEND:    n_state = S_DONE;
                    OP_PREPEND:   n_state = full ? S_DONE : (empty ? S_PUT : S_SH_UP);
                    OP_INS_AFTER: n_state = (full || empty) ? S_DONE : S_SCAN;
                    OP_FIND:      n_state = empty ? S_DONE : S_SCAN;
                    OP_POP_FRONT: n_state = empty ? S_DONE : S_FETCH;
                    OP_POP_BACK:  n_state = empty ? S_DONE : S_FETCH;
                    OP_DEL_CODE:  n_state = empty ? S_DONE : S_SCAN;
                    OP_CLEAR:     n_state = S_DONE;
                    default:      n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (scan_end) begin
                    if (!r_hit) begin
                        n_state = S_DONE;
                    end else if (op == OP_INS_AFTER) begin
                        n_state = r_dup ? S_DONE : ((pos_up == r_count) ? S_PUT : S_SH_UP);
                    end else if (op == OP_DEL_CODE) begin
                        n_state = S_SH_DN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FETCH: n_state = S_TAKE;
            S_TAKE:  n_state = S_SH_DN;
            S_SH_UP: begin
                if (!r_issue && !r_rv) n_state = S_PUT;
            end
            S_SH_DN: begin
                if (!r_issue && !r_rv) n_state = S_DONE;
            end
            S_PUT: n_state = S_DONE;
            S_DONE: begin
                if (load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_op      = r_op;
        n_code    = r_code;
        n_name    = r_name;
        n_match   = r_match;
        n_pay     = r_pay;
        n_idx     = r_idx;
        n_ridx    = r_ridx;
        n_pos     = r_pos;
        n_rv      = 1'b0;
        n_issue   = r_issue;
        n_hit     = r_hit;
        n_dup     = r_dup;
        n_status  = r_status;
        n_found   = r_found;
        n_ostatus = r_ostatus;
        n_orec    = r_orec;
        n_ofill   = r_ofill;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        ram_we    = 1'b0;
        w_waddr   = r_count;
        w_raddr   = r_idx;
        ram_wdata = '{code: r_code, name: r_name, payload: r_pay};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op     = i_req.op;
                    n_code   = i_req.rec_code;
                    n_name   = i_req.rec_name;
                    n_match  = i_req.match_name;
                    n_pay    = i_req.rec_payload;
                    n_idx    = '0;
                    n_hit    = 1'b0;
                    n_dup    = 1'b0;
                    n_status = ST_OK;
                end
            end
            S_DECODE: begin
                unique case (op)
                    OP_APPEND: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            ram_we  = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                    OP_PREPEND: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_pos   = '0;
                            n_idx   = cnt_dn;
                            n_issue = 1'b1;
                        end
                    end
                    OP_INS_AFTER: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else if (empty) begin
                            n_status = ST_EMPTY;
                        end
                    end
                    OP_FIND, OP_DEL_CODE: begin
                        if (empty) n_status = ST_EMPTY;
                    end
                    OP_POP_FRONT: begin
                        if (empty) n_status = ST_EMPTY;
                        n_pos = '0;
                    end
                    OP_POP_BACK: begin
                        if (empty) n_status = ST_EMPTY;
                        n_pos = cnt_dn;
                    end
                    OP_CLEAR: n_count = '0;
                    default:  n_count = r_count;
                endcase
            end
            S_SCAN: begin
                if (r_idx < r_count) begin
                    n_rv   = 1'b1;
                    n_ridx = r_idx;
                    n_idx  = idx_up;
                end
                if (key_hit && !r_hit) begin
                    n_hit   = 1'b1;
                    n_pos   = r_ridx;
                    n_found = rd;
                end
                if (code_hit) n_dup = 1'b1;
                if (scan_end) begin
                    if (!r_hit) begin
                        n_status = ST_MISS;
                    end else if (op == OP_INS_AFTER) begin
                        if (r_dup) begin
                            n_status = ST_DUP;
                        end else begin
                            n_pos   = pos_up;
                            n_idx   = cnt_dn;
                            n_issue = 1'b1;
                        end
                    end else if (op == OP_DEL_CODE) begin
                        n_idx   = pos_up;
                        n_issue = pos_up < r_count;
                    end
                end
            end
            S_FETCH: w_raddr = r_pos;
            S_TAKE: begin
                n_found = rd;
                n_idx   = pos_up;
                n_issue = pos_up < r_count;
            end
            S_SH_UP: begin
                if (r_issue) begin
                    n_rv   = 1'b1;
                    n_ridx = r_idx;
                    if (r_idx == r_pos) n_issue = 1'b0;
                    else                n_idx   = idx_dn;
                end
                if (r_rv) begin
                    ram_we    = 1'b1;
                    w_waddr   = ridx_up;
                    ram_wdata = rd;
                end
            end
            S_SH_DN: begin
                if (r_issue) begin
                    n_rv   = 1'b1;
                    n_ridx = r_idx;
                    if (r_idx == cnt_dn) n_issue = 1'b0;
                    else                 n_idx   = idx_up;
                end
                if (r_rv) begin
                    ram_we    = 1'b1;
                    w_waddr   = ridx_dn;
                    ram_wdata = rd;
                end
                if (!r_issue && !r_rv) n_count = cnt_dn;
            end
            S_PUT: begin
                ram_we  = 1'b1;
                w_waddr = r_pos;
                n_count = r_count + 1'b1;
            end
            S_DONE: begin
                if (load) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_orec    = report ? r_found : '0;
                    n_ofill   = r_count;
                end
            end
            default: n_ovalid = r_ovalid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_rv     <= 1'b0;
            r_issue  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_rv     <= n_rv;
            r_issue  <= n_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_code    <= n_code;
        r_name    <= n_name;
        r_match   <= n_match;
        r_pay     <= n_pay;
        r_idx     <= n_idx;
        r_ridx    <= n_ridx;
        r_pos     <= n_pos;
        r_hit     <= n_hit;
        r_dup     <= n_dup;
        r_status  <= n_status;
        r_found   <= n_found;
        r_ostatus <= n_ostatus;
        r_orec    <= n_orec;
        r_ofill   <= n_ofill;
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.status        = r_ostatus;
    assign o_rsp.found_code    = r_orec.code;
    assign o_rsp.found_name    = r_orec.name;
    assign o_rsp.found_payload = r_orec.payload;
    assign o_rsp.fill_count    = r_ofill;

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DECODE))
        else $error("Accepted beat did not move the sequencer to decode.");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((w_waddr < CW'(CAPACITY)) && (w_waddr <= r_count)))
        else $error("RAM write outside the held records.");

    a_shift_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ((r_state == S_SH_UP) || (r_state == S_SH_DN))) |-> (w_raddr != w_waddr))
        else $error("Shift reads and writes the same entry in one cycle.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (r_count <= CW'(CAPACITY)))
        else $error("Record count exceeds capacity.");

endmodule

`default_nettype wire
